>>> hdl/htfl_pkg.sv
// htfl_pkg: sizes, opcodes, type codes and beat structs for the handle table
// with a fifo free list. Used by htfl_exec and handle_table_free_list; depends on nothing.
package htfl_pkg;

  localparam int ENTRIES = 1024;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int FILL_W  = $clog2(ENTRIES + 1);
  localparam int CNT_W   = 17;

  localparam logic [3:0] OP_ALLOC       = 4'd0;
  localparam logic [3:0] OP_DELETE      = 4'd1;
  localparam logic [3:0] OP_GET_USER    = 4'd2;
  localparam logic [3:0] OP_SET_USER    = 4'd3;
  localparam logic [3:0] OP_GET_AUX     = 4'd4;
  localparam logic [3:0] OP_SET_AUX     = 4'd5;
  localparam logic [3:0] OP_GET_FLAGS   = 4'd6;
  localparam logic [3:0] OP_SET_FLAGS   = 4'd7;
  localparam logic [3:0] OP_CLEAR_FLAGS = 4'd8;
  localparam logic [3:0] OP_GET_TYPE    = 4'd9;

  localparam logic [7:0]  TYPE_NONE     = 8'd0;
  localparam logic [7:0]  TYPE_INVALID  = 8'd254;
  localparam logic [7:0]  TYPE_ANY      = 8'd255;
  localparam logic [31:0] FLAG_NODELETE = 32'h0000_0001;
  localparam logic [31:0] ALL_ONES      = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [3:0]  opcode;
    logic [15:0] handle_index;
    logic [7:0]  type_code;
    logic [31:0] value;
  } in_beat_t;

  typedef struct packed {
    logic              ok;
    logic [15:0]       result_index;
    logic [31:0]       read_value;
    logic [CNT_W-1:0]  live_count;
  } out_beat_t;

  typedef struct packed {
    logic [31:0] user_word;
    logic [31:0] aux_word;
    logic [31:0] flag_word;
    logic [7:0]  type_byte;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    out_beat_t         res;
    logic              e_we;
    logic [IDX_W-1:0]  e_waddr;
    entry_t            e_wdata;
    logic              q_we;
    logic [IDX_W-1:0]  q_waddr;
    logic [IDX_W-1:0]  q_wdata;
    logic [IDX_W-1:0]  head_nxt;
    logic [FILL_W-1:0] fill_nxt;
    logic [CNT_W-1:0]  count_nxt;
  } exec_t;

endpackage

>>> hdl/htfl_ram.sv
// htfl_ram: generic single write port, single read port ram with registered
// read data (old data on a same-cycle write). No package dependency.
module htfl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/htfl_exec.sv
// htfl_exec: evaluates one request against the entry and free-list head read
// for it; produces the result beat, ram writes and next queue state. Uses htfl_pkg.
module htfl_exec import htfl_pkg::*; (
  input  in_beat_t          st,
  input  entry_t            ent,
  input  logic [IDX_W-1:0]  q_head_data,
  input  logic [IDX_W-1:0]  head,
  input  logic [FILL_W-1:0] fill,
  input  logic [CNT_W-1:0]  count,
  output exec_t             ex
);

  logic              in_rng;
  logic              match;
  logic              used;
  logic [IDX_W-1:0]  idx;
  logic [IDX_W:0]    head_inc;
  logic [IDX_W-1:0]  head_wrap;
  logic [FILL_W:0]   tail_sum;
  logic [FILL_W:0]   tail_full;
  logic [IDX_W-1:0]  tail;

  always_comb begin
    in_rng = CNT_W'(st.handle_index) < CNT_W'(ENTRIES);
    idx    = st.handle_index[IDX_W-1:0];
    match  = in_rng && (((st.type_code == TYPE_ANY) && (ent.type_byte != TYPE_NONE)) ||
                        (st.type_code == ent.type_byte));
    used   = in_rng && (ent.type_byte != TYPE_NONE);

    head_inc  = (IDX_W+1)'(head) + (IDX_W+1)'(1);
    head_wrap = (head_inc == (IDX_W+1)'(ENTRIES)) ? '0 : head_inc[IDX_W-1:0];

    // tail slot = (head + fill) mod ENTRIES, sum stays below twice the depth
    tail_sum  = (FILL_W+1)'(head) + (FILL_W+1)'(fill);
    tail_full = (tail_sum >= (FILL_W+1)'(ENTRIES)) ? tail_sum - (FILL_W+1)'(ENTRIES)
                                                   : tail_sum;
    tail      = tail_full[IDX_W-1:0];

    ex           = '0;
    ex.e_waddr   = idx;
    ex.e_wdata   = ent;
    ex.q_waddr   = tail;
    ex.q_wdata   = idx;
    ex.head_nxt  = head;
    ex.fill_nxt  = fill;
    ex.count_nxt = count;

    case (st.opcode)
      OP_ALLOC: begin
        if (fill != '0) begin
          ex.head_nxt          = head_wrap;
          ex.fill_nxt          = fill - FILL_W'(1);
          ex.e_we              = 1'b1;
          ex.e_waddr           = q_head_data;
          ex.e_wdata.user_word = st.value;
          ex.e_wdata.aux_word  = '0;
          ex.e_wdata.flag_word = '0;
          ex.e_wdata.type_byte = st.type_code;
          if (count < CNT_W'(ENTRIES)) begin
            ex.count_nxt = count + CNT_W'(1);
          end
          ex.res.ok           = 1'b1;
          ex.res.result_index = 16'(q_head_data);
        end
      end
      OP_DELETE: begin
        if (in_rng) begin
          ex.res.ok = 1'b1;
          if (((ent.flag_word & FLAG_NODELETE) == '0) && (ent.type_byte != TYPE_NONE) &&
              (fill < FILL_W'(ENTRIES))) begin
            ex.e_we              = 1'b1;
            ex.e_wdata.user_word = '0;
            ex.e_wdata.type_byte = TYPE_NONE;
            ex.q_we              = 1'b1;
            ex.fill_nxt          = fill + FILL_W'(1);
            if (count != '0) begin
              ex.count_nxt = count - CNT_W'(1);
            end
          end
        end
      end
      OP_GET_USER: begin
        ex.res.ok         = match;
        ex.res.read_value = match ? ent.user_word : ALL_ONES;
      end
      OP_GET_AUX: begin
        ex.res.ok         = match;
        ex.res.read_value = match ? ent.aux_word : ALL_ONES;
      end
      OP_SET_USER: begin
        ex.res.ok            = match;
        ex.e_we              = match;
        ex.e_wdata.user_word = st.value;
      end
      OP_SET_AUX: begin
        ex.res.ok           = match;
        ex.e_we             = match;
        ex.e_wdata.aux_word = st.value;
      end
      OP_GET_FLAGS: begin
        ex.res.ok         = used;
        ex.res.read_value = used ? ent.flag_word : '0;
      end
      OP_SET_FLAGS: begin
        ex.res.ok            = used;
        ex.e_we              = used;
        ex.e_wdata.flag_word = ent.flag_word | st.value;
      end
      OP_CLEAR_FLAGS: begin
        ex.res.ok            = used;
        ex.e_we              = used;
        ex.e_wdata.flag_word = ent.flag_word & ~st.value;
      end
      OP_GET_TYPE: begin
        ex.res.ok         = used;
        ex.res.read_value = used ? 32'(ent.type_byte) : '0;
      end
      default: begin
        ex.res.ok = 1'b0;
      end
    endcase

    ex.res.live_count = ex.count_nxt;
  end

endmodule

>>> hdl/handle_table_free_list.sv
// handle_table_free_list: top level; request stage, result register, entry and
// free-list rams, same-cycle write forwarding and the clearing pass after reset.
// Uses htfl_pkg, htfl_ram and htfl_exec.
//
// Usage:
//   Requests enter on in_valid/in_stall/in_data, one beat per request; each
//   request gives exactly one result beat on out_valid/out_stall/out_data, in
//   request order. A beat moves on an edge with valid high and stall low.
//   Path: a request is taken into the request stage at its accept edge,
//   where the entry and the free-list head are read from ram, and moves into
//   the result register once that register is empty or its beat moves; its
//   result beat is then offered on out_valid/out_data.
//   Throughput: one request per cycle while no result is held by out_stall; a
//   read-modify-write of the same entry by back-to-back requests is covered by forwarding the last ram write.
//   Reset: after rst_n is released the block sweeps both rams, one entry per
//   cycle, ENTRIES cycles in all (1024 here), with in_stall held high; it then
//   holds the reserved entry 0 and indices 1 to ENTRIES-1 on the free list.
//   Stall: while out_stall holds a waiting result, one more request is taken
//   into the request stage, then in_stall rises until the result moves.
module handle_table_free_list import htfl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  logic              clearing_r;
  logic [IDX_W-1:0]  clr_cnt_r;
  logic              st_valid_r;
  in_beat_t          st_r;
  logic              out_valid_r;
  out_beat_t         out_data_r;
  logic [IDX_W-1:0]  head_r;
  logic [FILL_W-1:0] fill_r;
  logic [CNT_W-1:0]  count_r;

  logic              e_fwd_r;
  entry_t            e_fwd_data_r;
  logic              q_fwd_r;
  logic [IDX_W-1:0]  q_fwd_data_r;

  logic              fire;
  logic              accept;
  exec_t             ex;
  entry_t            ent;
  logic [IDX_W-1:0]  q_head_data;

  logic              e_we;
  logic [IDX_W-1:0]  e_waddr;
  entry_t            e_wdata;
  logic [IDX_W-1:0]  e_raddr;
  logic [ENTRY_W-1:0] e_rdata;
  logic              q_we;
  logic [IDX_W-1:0]  q_waddr;
  logic [IDX_W-1:0]  q_wdata;
  logic [IDX_W-1:0]  q_raddr;
  logic [IDX_W-1:0]  q_rdata;
  entry_t            clr_rec;
  logic              clr_first;
  logic              clr_last;

  assign fire     = st_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = clearing_r || (st_valid_r && !fire);
  assign accept   = in_valid && !in_stall;

  assign clr_first = (clr_cnt_r == '0);
  assign clr_last  = (clr_cnt_r == IDX_W'(ENTRIES - 1));

  always_comb begin
    clr_rec.user_word = clr_first ? ALL_ONES : '0;
    clr_rec.aux_word  = '0;
    clr_rec.flag_word = clr_first ? FLAG_NODELETE : '0;
    clr_rec.type_byte = clr_first ? TYPE_INVALID : TYPE_NONE;
  end

  // ram read data misses a write on the same edge, so take it from the bypass
  assign ent         = e_fwd_r ? e_fwd_data_r : entry_t'(e_rdata);
  assign q_head_data = q_fwd_r ? q_fwd_data_r : q_rdata;

  htfl_exec u_exec (
    .st          (st_r),
    .ent         (ent),
    .q_head_data (q_head_data),
    .head        (head_r),
    .fill        (fill_r),
    .count       (count_r),
    .ex          (ex)
  );

  always_comb begin
    if (clearing_r) begin
      e_we    = 1'b1;
      e_waddr = clr_cnt_r;
      e_wdata = clr_rec;
      q_we    = 1'b1;
      q_waddr = clr_cnt_r;
      q_wdata = clr_last ? '0 : clr_cnt_r + IDX_W'(1);
    end else begin
      e_we    = fire && ex.e_we;
      e_waddr = ex.e_waddr;
      e_wdata = ex.e_wdata;
      q_we    = fire && ex.q_we;
      q_waddr = ex.q_waddr;
      q_wdata = ex.q_wdata;
    end
    e_raddr = accept ? in_data.handle_index[IDX_W-1:0] : st_r.handle_index[IDX_W-1:0];
    q_raddr = fire ? ex.head_nxt : head_r;
  end

  htfl_ram #(.WIDTH(ENTRY_W), .DEPTH(ENTRIES)) u_entry_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  htfl_ram #(.WIDTH(IDX_W), .DEPTH(ENTRIES)) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (q_raddr),
    .rdata (q_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r  <= 1'b1;
      clr_cnt_r   <= '0;
      st_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      head_r      <= '0;
      fill_r      <= FILL_W'(ENTRIES - 1);
      count_r     <= CNT_W'(1);
      e_fwd_r     <= 1'b0;
      q_fwd_r     <= 1'b0;
    end else begin
      if (clearing_r) begin
        clr_cnt_r <= clr_cnt_r + IDX_W'(1);
        if (clr_last) begin
          clearing_r <= 1'b0;
        end
      end
      if (accept) begin
        st_valid_r <= 1'b1;
      end else if (fire) begin
        st_valid_r <= 1'b0;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
        head_r      <= ex.head_nxt;
        fill_r      <= ex.fill_nxt;
        count_r     <= ex.count_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      e_fwd_r <= e_we && (e_waddr == e_raddr);
      q_fwd_r <= q_we && (q_waddr == q_raddr);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st_r <= in_data;
    end
    if (fire) begin
      out_data_r <= ex.res;
    end
    e_fwd_data_r <= e_wdata;
    q_fwd_data_r <= q_wdata;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
